FILE: src/m3x3_pkg.sv
// Shared types and codes for the 3x3 matrix arithmetic unit.
package m3x3_pkg;

    // Operation codes carried on the input tuser.
    typedef enum logic [2:0] {
        KIND_LOAD_A  = 3'd0,
        KIND_LOAD_B  = 3'd1,
        KIND_ADD     = 3'd2,
        KIND_SUB     = 3'd3,
        KIND_SCALE_A = 3'd4,
        KIND_SCALE_B = 3'd5,
        KIND_MUL     = 3'd6
    } kind_t;

    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 2;
    localparam int TDATA_W    = 40;
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;
    localparam int OBUF_CW    = 3;

    // Per-beat control that rides along the datapath.
    typedef struct packed {
        logic               valid;
        kind_t              op;
        logic               first;   // first product of a dot product
        logic               fin;     // beat that completes a result element
        logic               last;    // final element of the matrix
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
    } ctl_t;

    // One result element; row sits in the low bits.
    typedef struct packed {
        logic               last;
        logic [ELEM_W-1:0]  element;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
    } res_t;

endpackage

FILE: src/matrix_3x3_arith_unit.sv
// Top level of the DIM x DIM matrix arithmetic unit.
// Holds matrices A and B (32-bit two's complement, cleared at reset) in two
// single-port-read memories and runs one command at a time. A beat on the
// slave stream carries the command kind on tuser: load A/B writes one element
// in the accept cycle and gives no output; kind 7 and loads with row or col
// not below DIM do nothing. Add, subtract and scale read one element of each
// memory per cycle while the output FIFO has room reserved; each such command
// runs from its accept through DIM*DIM element issues and the drain of the
// pipeline before the next accept; scale writes each product back into its
// matrix as it goes. Multiply does one multiply-accumulate per cycle, under the
// same condition, through the single read port of each memory, issuing
// DIM*DIM*DIM of them before the same drain. Results leave on the master stream
// in row-major order, tlast on the final element; a four-entry output FIFO lets
// the block finish and take the next command while results still wait, and
// issue pauses only when that FIFO has no room reserved. All arithmetic wraps
// modulo 2^32.
module matrix_3x3_arith_unit
    import m3x3_pkg::*;
#(
    parameter int DIM = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [1:0] row, [3:2] col, [35:4] value, rest 0
    input  logic [2:0]           s_tuser,   // [2:0] kind
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [1:0] out_row, [3:2] out_col, [35:4] element
    output logic                 m_tlast    // last
);

    localparam int NCELL = DIM * DIM;
    localparam int AW    = $clog2(NCELL);
    localparam int IW    = $clog2(DIM);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg;
    kind_t             op_reg;
    logic [ELEM_W-1:0] scalar_reg;
    logic [IW-1:0]     r_reg;
    logic [IW-1:0]     c_reg;
    logic [IW-1:0]     k_reg;
    ctl_t              ctl1_reg;
    logic [AW-1:0]     wb1_reg;
    logic [AW-1:0]     wb2_reg;

    // input beat decode
    logic              accept;
    kind_t             in_kind;
    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [ELEM_W-1:0] in_value;
    logic              load_ok;
    logic [AW-1:0]     load_addr;

    // issue side
    logic              is_mul;
    logic              k_end;
    logic              c_end;
    logic              r_end;
    logic [OBUF_CW-1:0] pend;
    logic              credit_ok;
    logic              issue;
    ctl_t              ctl0;
    logic [AW-1:0]     cell_addr;
    logic [AW-1:0]     a_raddr;
    logic [AW-1:0]     b_raddr;

    // memory ports
    logic              a_we;
    logic              b_we;
    logic [AW-1:0]     wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;

    // datapath and output
    ctl_t              ctl2;
    logic              push;
    res_t              push_beat;
    res_t              out_beat;
    logic [OBUF_CW-1:0] level;

    assign in_kind   = kind_t'(s_tuser);
    assign in_row    = s_tdata[1:0];
    assign in_col    = s_tdata[3:2];
    assign in_value  = s_tdata[35:4];
    assign load_ok   = (32'(in_row) < DIM) && (32'(in_col) < DIM);
    assign load_addr = AW'(32'(in_row) * DIM + 32'(in_col));

    // one command at a time: take a beat only with the pipeline drained
    assign s_tready = (state_reg == ST_IDLE) && !ctl1_reg.valid && !ctl2.valid;
    assign accept   = s_tvalid & s_tready;

    // element sequencing: k innermost for the dot product
    assign is_mul = (op_reg == KIND_MUL);
    assign k_end  = !is_mul || (32'(k_reg) == DIM - 1);
    assign c_end  = (32'(c_reg) == DIM - 1);
    assign r_end  = (32'(r_reg) == DIM - 1);

    // reserve a FIFO slot for every element between issue and push
    assign pend = OBUF_CW'(ctl1_reg.valid & ctl1_reg.fin)
                + OBUF_CW'(ctl2.valid & ctl2.fin);
    assign credit_ok = (level + pend) < OBUF_CW'(OBUF_DEPTH);
    assign issue     = (state_reg == ST_RUN) && credit_ok;

    assign cell_addr = AW'(32'(r_reg) * DIM + 32'(c_reg));
    assign a_raddr   = is_mul ? AW'(32'(r_reg) * DIM + 32'(k_reg)) : cell_addr;
    assign b_raddr   = is_mul ? AW'(32'(k_reg) * DIM + 32'(c_reg)) : cell_addr;

    always_comb
    begin
        ctl0.valid = issue;
        ctl0.op    = op_reg;
        ctl0.first = !is_mul || (k_reg == '0);
        ctl0.fin   = k_end;
        ctl0.last  = k_end && c_end && r_end;
        ctl0.row   = IDX_W'(r_reg);
        ctl0.col   = IDX_W'(c_reg);
    end

    // write port: loads in idle, scale write-back from the datapath otherwise
    always_comb
    begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        wr_addr = load_addr;
        wr_data = in_value;
        if (ctl2.valid && (ctl2.op == KIND_SCALE_A || ctl2.op == KIND_SCALE_B))
        begin
            a_we    = (ctl2.op == KIND_SCALE_A);
            b_we    = (ctl2.op == KIND_SCALE_B);
            wr_addr = wb2_reg;
            wr_data = push_beat.element;
        end
        else if (accept && load_ok)
        begin
            a_we = (in_kind == KIND_LOAD_A);
            b_we = (in_kind == KIND_LOAD_B);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= KIND_ADD;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            ctl1_reg  <= '0;
        end
        else
        begin
            ctl1_reg <= ctl0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        r_reg <= '0;
                        c_reg <= '0;
                        k_reg <= '0;
                        unique case (in_kind) inside
                            KIND_ADD, KIND_SUB, KIND_SCALE_A, KIND_SCALE_B, KIND_MUL:
                            begin
                                op_reg    <= in_kind;
                                state_reg <= ST_RUN;
                            end
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        if (!k_end)
                            k_reg <= k_reg + 1'b1;
                        else
                        begin
                            k_reg <= '0;
                            if (!c_end)
                                c_reg <= c_reg + 1'b1;
                            else
                            begin
                                c_reg <= '0;
                                if (!r_end)
                                    r_reg <= r_reg + 1'b1;
                                else
                                begin
                                    r_reg     <= '0;
                                    state_reg <= ST_IDLE;
                                end
                            end
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload side registers
    always_ff @(posedge clk)
    begin
        if (accept)
            scalar_reg <= in_value;
        wb1_reg <= cell_addr;
        wb2_reg <= wb1_reg;
    end

    m3x3_store #(
        .NCELL (NCELL)
    ) u_store_a (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    m3x3_store #(
        .NCELL (NCELL)
    ) u_store_b (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    m3x3_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl1_reg),
        .a_data    (a_rdata),
        .b_data    (b_rdata),
        .scalar    (scalar_reg),
        .ctl_out   (ctl2),
        .push      (push),
        .push_beat (push_beat)
    );

    m3x3_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .level     (level)
    );

    assign m_tdata = {(TDATA_W - ELEM_W - 2 * IDX_W)'(0),
                      out_beat.element, out_beat.col, out_beat.row};
    assign m_tlast = out_beat.last;

endmodule

FILE: src/m3x3_store.sv
// Matrix element store: one write port, one registered read port, per-entry valid bits.
module m3x3_store
    import m3x3_pkg::*;
#(
    parameter int NCELL = 9
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [$clog2(NCELL)-1:0]   waddr,
    input  logic [ELEM_W-1:0]          wdata,
    input  logic [$clog2(NCELL)-1:0]   raddr,
    output logic [ELEM_W-1:0]          rdata
);

    logic [ELEM_W-1:0] mem [NCELL];
    logic [NCELL-1:0]  vld_reg;
    logic [ELEM_W-1:0] rd_reg;
    logic              rvld_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[waddr] <= 1'b1;
            rvld_reg <= vld_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign rdata = rvld_reg ? rd_reg : '0;

endmodule

FILE: src/m3x3_mac.sv
// Element datapath: add/sub/multiply stage followed by the dot-product accumulator.
module m3x3_mac
    import m3x3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl_in,
    input  logic [ELEM_W-1:0] a_data,
    input  logic [ELEM_W-1:0] b_data,
    input  logic [ELEM_W-1:0] scalar,
    output ctl_t              ctl_out,
    output logic              push,
    output res_t              push_beat
);

    ctl_t              ctl2_reg;
    logic [ELEM_W-1:0] val_reg;
    logic [ELEM_W-1:0] val_next;
    logic [ELEM_W-1:0] acc_reg;
    logic [ELEM_W-1:0] acc_sum;
    logic [ELEM_W-1:0] mul_x;
    logic [ELEM_W-1:0] mul_y;
    logic [ELEM_W-1:0] prod;

    always_comb
    begin
        mul_x = (ctl_in.op == KIND_SCALE_B) ? b_data : a_data;
        mul_y = (ctl_in.op == KIND_MUL) ? b_data : scalar;
        prod  = mul_x * mul_y;   // low word only, wraps
        case (ctl_in.op) inside
            KIND_ADD:                   val_next = a_data + b_data;
            KIND_SUB:                   val_next = a_data - b_data;
            KIND_SCALE_A, KIND_SCALE_B,
            KIND_MUL:                   val_next = prod;
            default:                    val_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl2_reg <= '0;
        else
            ctl2_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (ctl2_reg.valid)
            acc_reg <= acc_sum;
    end

    assign acc_sum = (ctl2_reg.first ? '0 : acc_reg) + val_reg;

    assign ctl_out           = ctl2_reg;
    assign push              = ctl2_reg.valid & ctl2_reg.fin;
    assign push_beat.last    = ctl2_reg.last;
    assign push_beat.element = acc_sum;
    assign push_beat.col     = ctl2_reg.col;
    assign push_beat.row     = ctl2_reg.row;

endmodule

FILE: src/m3x3_obuf.sv
// Small result FIFO between the datapath and the output stream.
module m3x3_obuf
    import m3x3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  res_t               push_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               out_beat,
    output logic [OBUF_CW-1:0] level
);

    res_t               buf_mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0] wr_ptr_reg;
    logic [OBUF_AW-1:0] rd_ptr_reg;
    logic [OBUF_CW-1:0] cnt_reg;
    logic               pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_beat  = buf_mem[rd_ptr_reg];
    assign level     = cnt_reg;

    // push only arrives with room reserved upstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_mem[wr_ptr_reg] <= push_beat;
    end

endmodule

FILE: src/m3x3_chk.sv
// Port-level checks for the matrix arithmetic unit, bound to the top level.
module m3x3_chk
    import m3x3_pkg::*;
#(
    parameter int DIM = 3
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [2:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // pad bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TDATA_W-1:36] == '0)
        else $error("output pad bits set");

    // the closing element sits at the bottom-right corner
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(DIM - 1) && m_tdata[3:2] == 2'(DIM - 1))
        else $error("tlast away from the final element");

    // indexes stay inside the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (DIM > 3) || (32'(m_tdata[1:0]) < DIM && 32'(m_tdata[3:2]) < DIM))
        else $error("output index out of range");

    // an arithmetic command holds off the next beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_ADD || s_tuser == KIND_SUB ||
            s_tuser == KIND_SCALE_A || s_tuser == KIND_SCALE_B || s_tuser == KIND_MUL)
        |=> !s_tready)
        else $error("input taken during a matrix operation");

endmodule

bind matrix_3x3_arith_unit m3x3_chk #(.DIM(DIM)) u_chk (.*);

FILE: tb/testbench.sv
// Self-checking stream testbench for the 3x3 matrix arithmetic unit.
`timescale 1ns / 1ps

module testbench;
    import m3x3_pkg::*;

    localparam int           N           = 3;
    localparam int           CELLS       = N * N;
    localparam logic [2:0]   KIND_UNUSED = 3'd7;
    localparam int           CYCLE_LIMIT = 400000;
    localparam int           RANDOM_CMDS = 245;
    localparam int           HOLD_AFTER  = 40;   // commands taken before the long hold-off
    localparam int           HOLD_CYCLES = 400;
    localparam int           DRAIN_WAIT  = 60;

    // One command beat as driven on the slave stream
    typedef struct {
        logic [2:0]         kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ELEM_W-1:0]  value;
    } cmd_t;

    // One result element as it should leave the master stream
    typedef struct {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ELEM_W-1:0]  element;
        logic               last;
    } cell_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    cmd_t                 pending_cmds[$];
    cell_t                expected_cells[$];
    cmd_t                 next_cmd;

    // Shadow copies of the two matrices, row-major
    logic [ELEM_W-1:0]    mat_a [CELLS];
    logic [ELEM_W-1:0]    mat_b [CELLS];

    logic                 in_taken = 1'b0;
    int                   cmds_total = 0;
    int                   cmds_taken = 0;
    int                   cells_checked = 0;
    int                   mismatches = 0;
    int                   cycle_cnt = 0;
    int                   kind_seen [8];

    int                   send_gap = 0;
    int                   send_burst = 0;
    int                   recv_stall = 0;
    int                   recv_burst = 0;
    int                   hold_left = 0;
    bit                   hold_done = 1'b0;

    matrix_3x3_arith_unit #(.DIM(N)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic queue_cmd(input logic [2:0] kind, input int row, input int col,
                             input logic [ELEM_W-1:0] value);
        cmd_t c;
        c.kind  = kind;
        c.row   = row[IDX_W-1:0];
        c.col   = col[IDX_W-1:0];
        c.value = value;
        pending_cmds.push_back(c);
    endtask

    // Element values: full range, small signed, and the corners
    function automatic logic [ELEM_W-1:0] draw_element();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        else if (pick < 8)
            return ELEM_W'($urandom_range(0, 16) - 8);
        else
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0001;
                default: return 32'h0000_0000;
            endcase
    endfunction

    // Scale factors lean small so repeated scaling does not flush everything to zero
    function automatic logic [ELEM_W-1:0] draw_factor();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return ELEM_W'($urandom_range(0, 6) - 3);
        else if (pick < 5)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
        else if (pick < 6)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            return $urandom;
    endfunction

    task automatic push_cell(input int idx, input logic [ELEM_W-1:0] val);
        cell_t e;
        e.row     = IDX_W'(idx / N);
        e.col     = IDX_W'(idx % N);
        e.element = val;
        e.last    = (idx == CELLS - 1);
        expected_cells.push_back(e);
    endtask

    // Apply one accepted command to the shadow matrices and queue its results
    task automatic predict_command(input cmd_t c);
        logic [ELEM_W-1:0] acc;
        case (c.kind) inside
            KIND_LOAD_A, KIND_LOAD_B:
            begin
                // out-of-range loads fall through silently
                if (c.row < N && c.col < N)
                begin
                    if (c.kind == KIND_LOAD_A)
                        mat_a[c.row * N + c.col] = c.value;
                    else
                        mat_b[c.row * N + c.col] = c.value;
                end
            end
            KIND_ADD:
                for (int i = 0; i < CELLS; i++)
                    push_cell(i, mat_a[i] + mat_b[i]);
            KIND_SUB:
                for (int i = 0; i < CELLS; i++)
                    push_cell(i, mat_a[i] - mat_b[i]);
            KIND_SCALE_A:
                for (int i = 0; i < CELLS; i++)
                begin
                    mat_a[i] = mat_a[i] * c.value;
                    push_cell(i, mat_a[i]);
                end
            KIND_SCALE_B:
                for (int i = 0; i < CELLS; i++)
                begin
                    mat_b[i] = mat_b[i] * c.value;
                    push_cell(i, mat_b[i]);
                end
            KIND_MUL:
                for (int r = 0; r < N; r++)
                    for (int k = 0; k < N; k++)
                    begin
                        acc = '0;
                        for (int j = 0; j < N; j++)
                            acc = acc + mat_a[r * N + j] * mat_b[j * N + k];
                        push_cell(r * N + k, acc);
                    end
            default:
                ;   // unused kind: no effect
        endcase
    endtask

    // Input side: record each accepted beat and predict from what was on the bus
    always @(posedge clk)
    begin
        cmd_t c;
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            c.kind  = s_tuser;
            c.row   = s_tdata[1:0];
            c.col   = s_tdata[3:2];
            c.value = s_tdata[35:4];
            kind_seen[c.kind] = kind_seen[c.kind] + 1;
            predict_command(c);
            cmds_taken <= cmds_taken + 1;
        end
    end

    // Driver: next beat goes out once the current one was taken, after its gap
    always @(negedge clk)
    begin
        int pick;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                s_tdata  <= {4'b0, next_cmd.value, next_cmd.col, next_cmd.row};
                s_tuser  <= next_cmd.kind;
                s_tvalid <= 1'b1;
                // mostly back-to-back or short gaps, now and then a long one
                pick = $urandom_range(0, 99);
                if (send_burst > 0)
                begin
                    send_burst = send_burst - 1;
                    send_gap <= 0;
                end
                else if (pick < 8)
                begin
                    send_burst = $urandom_range(10, 30);
                    send_gap <= 0;
                end
                else if (pick < 55)
                    send_gap <= 0;
                else if (pick < 88)
                    send_gap <= $urandom_range(1, 3);
                else if (pick < 96)
                    send_gap <= $urandom_range(4, 12);
                else
                    send_gap <= $urandom_range(20, 60);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver ready: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        int pick;
        if (rst_n)
        begin
            if (!hold_done && cmds_taken >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (recv_stall > 0)
            begin
                m_tready <= 1'b0;
                recv_stall = recv_stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                pick = $urandom_range(0, 99);
                if (recv_burst > 0)
                    recv_burst = recv_burst - 1;
                else if (pick < 5)
                    recv_burst = $urandom_range(15, 40);
                else if (pick < 60)
                    recv_stall = 0;
                else if (pick < 88)
                    recv_stall = $urandom_range(1, 3);
                else if (pick < 97)
                    recv_stall = $urandom_range(4, 12);
                else
                    recv_stall = $urandom_range(20, 50);
            end
        end
    end

    // Monitor: each result beat against the oldest expected element
    always @(posedge clk)
    begin
        cell_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cells.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat: row %0d col %0d element %h last %b",
                             $realtime, m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
            end
            else
            begin
                e = expected_cells.pop_front();
                cells_checked = cells_checked + 1;
                if (m_tdata[1:0] !== e.row || m_tdata[3:2] !== e.col
                    || m_tdata[35:4] !== e.element || m_tlast !== e.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] result mismatch: expected row %0d col %0d element %h last %b",
                                 $realtime, e.row, e.col, e.element, e.last);
                        $display("    got row %0d col %0d element %h last %b",
                                 m_tdata[1:0], m_tdata[3:2], m_tdata[35:4], m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d commands taken, %0d results outstanding",
                     cycle_cnt, cmds_taken, expected_cells.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int  useful;
        int  loads;
        int  ops;
        int  r;
        int  c;
        logic [2:0] op;

        for (int i = 0; i < CELLS; i++)
        begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            kind_seen[i] = 0;

        // Directed: cleared matrices, corner values, ignored beats, every operation
        queue_cmd(KIND_ADD,     0, 0, 32'h0);
        queue_cmd(KIND_MUL,     3, 3, 32'hFFFF_FFFF);
        queue_cmd(KIND_LOAD_A,  0, 0, 32'h7FFF_FFFF);
        queue_cmd(KIND_LOAD_A,  1, 1, 32'hFFFF_FFFF);
        queue_cmd(KIND_LOAD_A,  2, 2, 32'h8000_0000);
        queue_cmd(KIND_LOAD_A,  0, 2, 32'h0000_0003);
        queue_cmd(KIND_LOAD_B,  0, 0, 32'h0000_0001);
        queue_cmd(KIND_LOAD_B,  1, 1, 32'h8000_0000);
        queue_cmd(KIND_LOAD_B,  2, 2, 32'hFFFF_FFFF);
        queue_cmd(KIND_LOAD_B,  2, 0, 32'h7FFF_FFFF);
        // loads off the matrix edge and the unused kind must leave state alone
        queue_cmd(KIND_LOAD_A,  3, 0, 32'hA5A5_A5A5);
        queue_cmd(KIND_LOAD_B,  0, 3, 32'h5A5A_5A5A);
        queue_cmd(KIND_LOAD_A,  3, 3, 32'hFFFF_FFFF);
        queue_cmd(KIND_UNUSED,  3, 3, 32'hFFFF_FFFF);
        queue_cmd(KIND_ADD,     0, 0, 32'h0);
        queue_cmd(KIND_SUB,     0, 0, 32'h0);
        queue_cmd(KIND_MUL,     0, 0, 32'h0);
        queue_cmd(KIND_SCALE_A, 0, 0, 32'h0000_0002);
        queue_cmd(KIND_SCALE_B, 0, 0, 32'hFFFF_FFFF);
        queue_cmd(KIND_SCALE_B, 0, 0, 32'h8000_0000);
        queue_cmd(KIND_MUL,     2, 1, 32'h0);
        queue_cmd(KIND_SCALE_A, 0, 0, 32'h0);
        queue_cmd(KIND_SUB,     0, 0, 32'h0);

        // Random: bursts of loads followed by a few operations, with some noise
        useful = 0;
        while (useful < RANDOM_CMDS)
        begin
            loads = ($urandom_range(0, 4) == 0) ? CELLS : $urandom_range(1, 6);
            for (int i = 0; i < loads; i++)
            begin
                if (loads == CELLS)
                    queue_cmd(KIND_LOAD_A, i / N, i % N, draw_element());
                else
                    queue_cmd($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                              $urandom_range(0, 2), $urandom_range(0, 2), draw_element());
                useful = useful + 1;
            end
            ops = $urandom_range(1, 3);
            for (int i = 0; i < ops; i++)
            begin
                op = 3'($urandom_range(KIND_ADD, KIND_MUL));
                // row and col are don't-care for operations; toggle them anyway
                queue_cmd(op, $urandom_range(0, 3), $urandom_range(0, 3),
                          (op == KIND_SCALE_A || op == KIND_SCALE_B) ? draw_factor()
                                                                     : 32'($urandom));
                useful = useful + 1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    queue_cmd(KIND_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom);
                else
                begin
                    r = $urandom_range(0, 3);
                    c = (r == 3) ? $urandom_range(0, 3) : 3;
                    queue_cmd($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A, r, c,
                              $urandom);
                end
            end
        end
        cmds_total = pending_cmds.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmds_taken < cmds_total)
            @(posedge clk);
        while (expected_cells.size() > 0)
            @(posedge clk);
        // catch any stray beats after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d commands: %0d loads A, %0d loads B, %0d add, %0d sub, %0d unused",
                 cmds_taken, kind_seen[KIND_LOAD_A], kind_seen[KIND_LOAD_B],
                 kind_seen[KIND_ADD], kind_seen[KIND_SUB], kind_seen[KIND_UNUSED]);
        $display("%0d scale A, %0d scale B, %0d multiply; %0d result beats checked, %0d bad",
                 kind_seen[KIND_SCALE_A], kind_seen[KIND_SCALE_B], kind_seen[KIND_MUL],
                 cells_checked, mismatches);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: matrix_3x3_arith_unit.f
src/m3x3_pkg.sv
src/m3x3_store.sv
src/m3x3_mac.sv
src/m3x3_obuf.sv
src/matrix_3x3_arith_unit.sv
src/m3x3_chk.sv
tb/testbench.sv
